[rtl/pip_pkg.sv]
`timescale 1ns / 1ps
// Package for the point-in-polygon test block.
// Holds fixed field widths and the function codes of an input word; no dependencies.
package pip_pkg;

   // Fixed field widths of the command and configuration words.
   localparam int CFG_W = 7;
   localparam int IDX_W = 6;

   // Function codes of an input word.
   typedef enum logic [0:0] {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   // Tags that travel with a vertex read down the edge pipeline.
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } rd_tag_type;

endpackage

[rtl/point_in_polygon_test_top.sv]
`timescale 1ns / 1ps
// Point-in-polygon test by the even-odd crossing rule, with a vertex memory and edge pipeline.
// Depends on pip_pkg for field widths, function codes and the read tag type.

// A vertex write (func 0) gives no result word; busy stays low.
// A query (func 1) holds busy high while the block walks the polygon one edge per
// cycle from a vertex memory with a registered read. It reads n + 1 vertices (none
// when n is zero), where n is vertex_count capped at MAX_VERTICES. The inside
// word is registered onto rsp_valid after the last edge leaves stage B, or from
// the walk state when n is zero. busy falls in the cycle that shows the result,
// so a new word can be started there. The receiver cannot stall: each result is
// shown for exactly one cycle. vertex_count may only be written while busy is low.
module point_in_polygon_test_top
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_WIDTH  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // Command channel
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [IDX_W-1:0]              req_vertex_index,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   // Result channel
   output logic                          rsp_valid,
   output logic                          rsp_inside_res,
   // Configuration
   input  logic                          csr_wr_en,
   input  logic [CFG_W-1:0]              csr_wr_data
);

   localparam int CW   = COORD_WIDTH;
   localparam int DW   = CW + 1;
   localparam int PW   = 2 * DW;
   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int NW   = $clog2(MAX_VERTICES + 1);
   localparam int CMPW = (NW > CFG_W) ? NW : CFG_W;

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_WALK = 1'b1;

   // Configuration register.
   logic [CFG_W-1:0] vcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= CFG_W'(3);
      end else if (csr_wr_en) begin
         vcount_ff <= csr_wr_data;
      end
   end

   // Vertex count in use, capped at the store depth.
   logic [NW-1:0] n_sat;
   assign n_sat = (CMPW'(vcount_ff) > CMPW'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                           : NW'(vcount_ff);

   // Input word decode.
   logic accept;
   logic is_query;
   logic mem_we;
   assign accept   = start && !busy;
   assign is_query = (req_func == FUNC_QUERY);
   assign mem_we   = accept && !is_query &&
                     (32'(req_vertex_index) < 32'(MAX_VERTICES));

   // Control state.
   logic [0:0]     state_ff, state_in;
   logic [NW-1:0]  n_ff;
   logic [NW-1:0]  rd_cnt_ff;
   logic           rd_active_ff;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic [NW-1:0]  n_minus1;
   logic [NW-1:0]  cnt_minus1;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_inside_ff;
   logic           parity_ff;
   logic           parity_in;

   assign busy = (state_ff == ST_WALK);

   // Vertex read address: the closing vertex first, then vertices 0 to n-1.
   assign rd_en      = rd_active_ff;
   assign n_minus1   = n_ff - NW'(1);
   assign cnt_minus1 = rd_cnt_ff - NW'(1);
   assign rd_addr    = (rd_cnt_ff == '0) ? n_minus1[AW-1:0] : cnt_minus1[AW-1:0];

   // Vertex memory: one entry of {x, y} per slot, registered read.
   logic [2*CW-1:0] vertex_mem_ff [MAX_VERTICES];
   logic [2*CW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         vertex_mem_ff[AW'(req_vertex_index)] <= {req_coord_x, req_coord_y};
      end
      if (rd_en) begin
         rd_data_ff <= vertex_mem_ff[rd_addr];
      end
   end

   // Query point, held for the whole walk.
   logic signed [CW-1:0] qx_ff, qy_ff;

   always_ff @(posedge clock) begin
      if (accept && is_query) begin
         qx_ff <= req_coord_x;
         qy_ff <= req_coord_y;
      end
   end

   // Read sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_active_ff <= 1'b0;
      end else if (accept && is_query) begin
         rd_active_ff <= (n_sat != '0);
      end else if (rd_active_ff && (rd_cnt_ff == n_ff)) begin
         rd_active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_query) begin
         n_ff      <= n_sat;
         rd_cnt_ff <= '0;
      end else if (rd_active_ff) begin
         rd_cnt_ff <= rd_cnt_ff + NW'(1);
      end
   end

   // Tag of the word now on the memory output.
   rd_tag_type s1_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
      end else begin
         s1_tag_ff.vld   <= rd_en;
         s1_tag_ff.first <= (rd_cnt_ff == '0);
         s1_tag_ff.last  <= (rd_cnt_ff == n_ff);
      end
   end

   // Edge stage A: current vertex i from memory, previous vertex j held here.
   logic signed [CW-1:0] xi, yi;
   logic signed [CW-1:0] xj_ff, yj_ff;
   assign xi = $signed(rd_data_ff[2*CW-1:CW]);
   assign yi = $signed(rd_data_ff[CW-1:0]);

   always_ff @(posedge clock) begin
      if (s1_tag_ff.vld) begin
         xj_ff <= xi;
         yj_ff <= yi;
      end
   end

   logic                 sa_vld_ff, sa_last_ff, sa_str_ff;
   logic signed [DW-1:0] sa_dx_ff, sa_dy_ff, sa_qxd_ff, sa_qyd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff <= 1'b0;
      end else begin
         sa_vld_ff <= s1_tag_ff.vld && !s1_tag_ff.first;
      end
   end

   always_ff @(posedge clock) begin
      sa_last_ff <= s1_tag_ff.last;
      sa_str_ff  <= ((yi < qy_ff) && (yj_ff >= qy_ff)) ||
                    ((yj_ff < qy_ff) && (yi >= qy_ff));
      sa_dx_ff   <= DW'(xj_ff) - DW'(xi);
      sa_dy_ff   <= DW'(yj_ff) - DW'(yi);
      sa_qxd_ff  <= DW'(qx_ff) - DW'(xi);
      sa_qyd_ff  <= DW'(qy_ff) - DW'(yi);
   end

   // Edge stage B: cross products for the crossing test.
   logic                 sb_vld_ff, sb_last_ff, sb_str_ff, sb_dypos_ff;
   logic signed [PW-1:0] sb_lhs_ff, sb_rhs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_vld_ff <= 1'b0;
      end else begin
         sb_vld_ff <= sa_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sb_last_ff  <= sa_last_ff;
      sb_str_ff   <= sa_str_ff;
      sb_dypos_ff <= (sa_dy_ff > DW'(0));
      sb_lhs_ff   <= PW'(sa_qyd_ff) * PW'(sa_dx_ff);
      sb_rhs_ff   <= PW'(sa_qxd_ff) * PW'(sa_dy_ff);
   end

   // Edge stage C: compare in the direction of dy and toggle the parity.
   logic left;
   assign left      = sb_dypos_ff ? (sb_lhs_ff < sb_rhs_ff) : (sb_rhs_ff < sb_lhs_ff);
   assign parity_in = parity_ff ^ (sb_vld_ff && sb_str_ff && left);

   always_ff @(posedge clock) begin
      if (accept && is_query) begin
         parity_ff <= 1'b0;
      end else begin
         parity_ff <= parity_in;
      end
   end

   // Result word and state update.
   assign rsp_valid_in = busy && ((n_ff == '0) || (sb_vld_ff && sb_last_ff));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (rsp_valid_in) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_inside_ff <= (n_ff == '0) ? 1'b0 : parity_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

   // Checks on the walk sequencing.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy))
      else $error("result word without a query in progress");

   a_idle_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("busy still high while the result word is shown");

   a_read_when_busy: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> busy)
      else $error("vertex read outside a query");

   a_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !busy)
      else $error("vertex write during a query");

   a_edge_when_busy: assert property (@(posedge clock) disable iff (reset)
      sb_vld_ff |-> busy)
      else $error("edge result outside a query");

endmodule
